// ===== src/smix_pkg.sv =====
`timescale 1ns / 1ps

package smix_pkg;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 18;
  localparam int ALPHA_W  = 16;
  localparam int BETA_W   = ALPHA_W + 1;
  localparam int PROD_W   = 44;
  localparam int CFG_AW   = 4;
  localparam int CFG_DW   = 32;

  // register word indexes (byte address / 4)
  localparam logic [1:0] REG_FADE    = 2'd0;
  localparam logic [1:0] REG_ALPHA   = 2'd1;
  localparam logic [1:0] REG_TARGET_A = 2'd2;
  localparam logic [1:0] REG_TARGET_B = 2'd3;

  localparam logic                FADE_RST   = 1'b1;
  localparam logic [ALPHA_W-1:0]  ALPHA_RST  = 16'd65470;
  localparam logic [GAIN_W-1:0]   TARGET_RST = 18'd65529;

  // operand pairs for the shared multiplier
  localparam logic [2:0] MUL_TA_BETA  = 3'd0;
  localparam logic [2:0] MUL_GA_ALPHA = 3'd1;
  localparam logic [2:0] MUL_TB_BETA  = 3'd2;
  localparam logic [2:0] MUL_GB_ALPHA = 3'd3;
  localparam logic [2:0] MUL_SA_GAIN  = 3'd4;
  localparam logic [2:0] MUL_SB_GAIN  = 3'd5;

  typedef struct packed {
    logic       in_load;
    logic [2:0] mul_sel;
    logic       acc_load;
    logic       gain_a_we;
    logic       gain_b_we;
    logic       out_load;
  } smix_cmd_t;

  typedef struct packed {
    logic out_busy;
  } smix_status_t;

endpackage

// ===== src/smix_regs.sv =====
`timescale 1ns / 1ps

module smix_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [smix_pkg::CFG_AW-1:0]     cfg_paddr,
  input  logic [smix_pkg::CFG_DW-1:0]     cfg_pwdata,
  output logic [smix_pkg::CFG_DW-1:0]     cfg_prdata,
  output logic                            cfg_pready,
  output logic                            fading_enable,
  output logic [smix_pkg::ALPHA_W-1:0]    smoothing_alpha,
  output logic [smix_pkg::GAIN_W-1:0]     target_gain_a,
  output logic [smix_pkg::GAIN_W-1:0]     target_gain_b
);

  logic                         fade_r;
  logic [smix_pkg::ALPHA_W-1:0] alpha_r;
  logic [smix_pkg::GAIN_W-1:0]  tga_r;
  logic [smix_pkg::GAIN_W-1:0]  tgb_r;
  logic                         wr_en;
  logic                         aligned;
  logic [1:0]                   reg_idx;

  assign cfg_pready = 1'b1;
  assign aligned    = (cfg_paddr[1:0] == 2'b00);
  assign reg_idx    = cfg_paddr[3:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && aligned;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_r  <= smix_pkg::FADE_RST;
      alpha_r <= smix_pkg::ALPHA_RST;
      tga_r   <= smix_pkg::TARGET_RST;
      tgb_r   <= smix_pkg::TARGET_RST;
    end else if (wr_en) begin
      case (reg_idx)
        smix_pkg::REG_FADE:     fade_r  <= cfg_pwdata[0];
        smix_pkg::REG_ALPHA:    alpha_r <= cfg_pwdata[smix_pkg::ALPHA_W-1:0];
        smix_pkg::REG_TARGET_A: tga_r   <= cfg_pwdata[smix_pkg::GAIN_W-1:0];
        smix_pkg::REG_TARGET_B: tgb_r   <= cfg_pwdata[smix_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (aligned) begin
      case (reg_idx)
        smix_pkg::REG_FADE:     cfg_prdata = {31'd0, fade_r};
        smix_pkg::REG_ALPHA:    cfg_prdata = {16'd0, alpha_r};
        smix_pkg::REG_TARGET_A: cfg_prdata = {14'd0, tga_r};
        smix_pkg::REG_TARGET_B: cfg_prdata = {14'd0, tgb_r};
        default:                cfg_prdata = '0;
      endcase
    end
  end

  assign fading_enable   = fade_r;
  assign smoothing_alpha = alpha_r;
  assign target_gain_a   = tga_r;
  assign target_gain_b   = tgb_r;

endmodule

// ===== src/smix_dp.sv =====
`timescale 1ns / 1ps

module smix_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  smix_pkg::smix_cmd_t                 cmd,
  output smix_pkg::smix_status_t              status,
  input  logic                                fading_enable,
  input  logic [smix_pkg::ALPHA_W-1:0]        smoothing_alpha,
  input  logic [smix_pkg::GAIN_W-1:0]         target_gain_a,
  input  logic [smix_pkg::GAIN_W-1:0]         target_gain_b,
  input  logic signed [smix_pkg::SAMPLE_W-1:0] sample_a,
  input  logic signed [smix_pkg::SAMPLE_W-1:0] sample_b,
  input  logic                                frame_last,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [smix_pkg::SAMPLE_W-1:0] mixed_sample,
  output logic                                out_frame_last,
  output logic                                saturated
);

  localparam int RES_W = smix_pkg::PROD_W - 16;

  logic signed [smix_pkg::SAMPLE_W-1:0] sa_r;
  logic signed [smix_pkg::SAMPLE_W-1:0] sb_r;
  logic                                 last_r;
  logic [smix_pkg::GAIN_W-1:0]          cga_r;
  logic [smix_pkg::GAIN_W-1:0]          cgb_r;
  logic signed [smix_pkg::PROD_W-1:0]   p_r;
  logic signed [smix_pkg::PROD_W-1:0]   acc_r;
  logic                                 out_valid_r;
  logic signed [smix_pkg::SAMPLE_W-1:0] mix_r;
  logic                                 olast_r;
  logic                                 sat_r;

  logic [smix_pkg::BETA_W-1:0]          beta;
  logic [smix_pkg::GAIN_W-1:0]          ga_sel;
  logic [smix_pkg::GAIN_W-1:0]          gb_sel;
  logic signed [smix_pkg::SAMPLE_W:0]   op_a;
  logic signed [smix_pkg::GAIN_W:0]     op_b;
  logic signed [smix_pkg::PROD_W-1:0]   p_nxt;
  logic signed [smix_pkg::PROD_W-1:0]   sum_rnd;
  logic [smix_pkg::GAIN_W-1:0]          gain_nxt;
  logic signed [RES_W-1:0]              res;
  logic                                 clip;
  logic signed [smix_pkg::SAMPLE_W-1:0] mix_nxt;

  assign beta   = smix_pkg::BETA_W'(17'h10000 - {1'b0, smoothing_alpha});
  assign ga_sel = fading_enable ? cga_r : target_gain_a;
  assign gb_sel = fading_enable ? cgb_r : target_gain_b;

  // shared multiplier, operands sign-extended or zero-extended as needed
  always_comb begin
    case (cmd.mul_sel)
      smix_pkg::MUL_TA_BETA: begin
        op_a = {7'd0, target_gain_a};
        op_b = {2'd0, beta};
      end
      smix_pkg::MUL_GA_ALPHA: begin
        op_a = {7'd0, cga_r};
        op_b = {3'd0, smoothing_alpha};
      end
      smix_pkg::MUL_TB_BETA: begin
        op_a = {7'd0, target_gain_b};
        op_b = {2'd0, beta};
      end
      smix_pkg::MUL_GB_ALPHA: begin
        op_a = {7'd0, cgb_r};
        op_b = {3'd0, smoothing_alpha};
      end
      smix_pkg::MUL_SA_GAIN: begin
        op_a = {sa_r[smix_pkg::SAMPLE_W-1], sa_r};
        op_b = {1'b0, ga_sel};
      end
      smix_pkg::MUL_SB_GAIN: begin
        op_a = {sb_r[smix_pkg::SAMPLE_W-1], sb_r};
        op_b = {1'b0, gb_sel};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign p_nxt = smix_pkg::PROD_W'(op_a * op_b);

  // round half up: add 2^15 then drop 16 fraction bits
  assign sum_rnd  = acc_r + p_r + 44'sd32768;
  assign gain_nxt = sum_rnd[smix_pkg::GAIN_W+15:16];
  assign res      = sum_rnd[smix_pkg::PROD_W-1:16];
  assign clip     = !((&res[RES_W-1:smix_pkg::SAMPLE_W-1]) ||
                      !(|res[RES_W-1:smix_pkg::SAMPLE_W-1]));

  always_comb begin
    if (!clip) begin
      mix_nxt = res[smix_pkg::SAMPLE_W-1:0];
    end else if (res[RES_W-1]) begin
      mix_nxt = {1'b1, {(smix_pkg::SAMPLE_W-1){1'b0}}};
    end else begin
      mix_nxt = {1'b0, {(smix_pkg::SAMPLE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      sa_r   <= sample_a;
      sb_r   <= sample_b;
      last_r <= frame_last;
    end
    p_r <= p_nxt;
    if (cmd.acc_load) begin
      acc_r <= p_r;
    end
    if (cmd.out_load) begin
      mix_r   <= mix_nxt;
      olast_r <= last_r;
      sat_r   <= clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cga_r       <= '0;
      cgb_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.gain_a_we) begin
        cga_r <= gain_nxt;
      end
      if (cmd.gain_b_we) begin
        cgb_r <= gain_nxt;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.out_busy = out_valid_r && !out_ready;
  assign out_valid       = out_valid_r;
  assign mixed_sample    = mix_r;
  assign out_frame_last  = olast_r;
  assign saturated       = sat_r;

  // a finished result never lands on one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");

  a_gain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.gain_a_we && !cmd.gain_b_we |=> $stable(cga_r) && $stable(cgb_r))
    else $error("kept gain changed without write");

endmodule

// ===== src/smix_ctrl.sv =====
`timescale 1ns / 1ps

module smix_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    fading_enable,
  input  smix_pkg::smix_status_t  status,
  output smix_pkg::smix_cmd_t     cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_GA_T   = 3'd1;
  localparam logic [2:0] S_GA_P   = 3'd2;
  localparam logic [2:0] S_GB_T   = 3'd3;
  localparam logic [2:0] S_GB_P   = 3'd4;
  localparam logic [2:0] S_MX_A   = 3'd5;
  localparam logic [2:0] S_MX_B   = 3'd6;
  localparam logic [2:0] S_MX_SUM = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.in_load = accept;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = fading_enable ? S_GA_T : S_MX_A;
        end
      end
      S_GA_T: begin
        cmd.mul_sel = smix_pkg::MUL_TA_BETA;
        state_nxt   = S_GA_P;
      end
      S_GA_P: begin
        cmd.mul_sel  = smix_pkg::MUL_GA_ALPHA;
        cmd.acc_load = 1'b1;
        state_nxt    = S_GB_T;
      end
      S_GB_T: begin
        cmd.mul_sel   = smix_pkg::MUL_TB_BETA;
        cmd.gain_a_we = 1'b1;
        state_nxt     = S_GB_P;
      end
      S_GB_P: begin
        cmd.mul_sel  = smix_pkg::MUL_GB_ALPHA;
        cmd.acc_load = 1'b1;
        state_nxt    = S_MX_A;
      end
      S_MX_A: begin
        cmd.mul_sel   = smix_pkg::MUL_SA_GAIN;
        // only the smoothing path has a gain b update pending here
        cmd.gain_b_we = fading_enable;
        state_nxt     = S_MX_B;
      end
      S_MX_B: begin
        cmd.mul_sel  = smix_pkg::MUL_SB_GAIN;
        cmd.acc_load = 1'b1;
        state_nxt    = S_MX_SUM;
      end
      S_MX_SUM: begin
        cmd.mul_sel = smix_pkg::MUL_SB_GAIN;
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_fade_path: assert property (@(posedge clk) disable iff (!rst_n)
    accept && fading_enable |=> state_r == S_GA_T)
    else $error("smoothing path not entered");

  a_direct_path: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !fading_enable |=> state_r == S_MX_A)
    else $error("direct path not entered");

  a_sum_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MX_SUM && status.out_busy |=> state_r == S_MX_SUM)
    else $error("sum step left while result slot busy");

endmodule

// ===== src/smoothed_two_input_mixer.sv =====
`timescale 1ns / 1ps

// channel | ports        | contents
// input   | in_t*        | tdata: sample_a[23:0], sample_b[47:24]; tlast: frame_last
// result  | out_t*       | tdata: mixed_sample[23:0]; tlast: frame_last; tuser: saturated
// config  | cfg_p*       | 0x0 fading_enable, 0x4 alpha, 0x8 target a, 0xC target b
//
// with fading on, each item runs four gain products and two mix products
// through one 25x19 multiplier; with fading off, only the two mix products.
// the result register holds a finished sample while the next one is taken in.
// a stalled result holds the sum step until the register frees up.
// rst_n is synchronous; it clears the kept gains and restores register defaults.

module smoothed_two_input_mixer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [47:0]                      in_tdata,   // sample_a, sample_b
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [23:0]                      out_tdata,  // mixed_sample
  output logic                             out_tlast,
  output logic                             out_tuser,  // saturated
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [smix_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [smix_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [smix_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                             cfg_pready
);

  smix_pkg::smix_cmd_t           cmd;
  smix_pkg::smix_status_t        status;
  logic                          fading_enable;
  logic [smix_pkg::ALPHA_W-1:0]  smoothing_alpha;
  logic [smix_pkg::GAIN_W-1:0]   target_gain_a;
  logic [smix_pkg::GAIN_W-1:0]   target_gain_b;

  smix_regs u_regs (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready),
    .fading_enable   (fading_enable),
    .smoothing_alpha (smoothing_alpha),
    .target_gain_a   (target_gain_a),
    .target_gain_b   (target_gain_b)
  );

  smix_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .fading_enable (fading_enable),
    .status        (status),
    .cmd           (cmd)
  );

  smix_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .fading_enable   (fading_enable),
    .smoothing_alpha (smoothing_alpha),
    .target_gain_a   (target_gain_a),
    .target_gain_b   (target_gain_b),
    .sample_a        (in_tdata[23:0]),
    .sample_b        (in_tdata[47:24]),
    .frame_last      (in_tlast),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .mixed_sample    (out_tdata),
    .out_frame_last  (out_tlast),
    .saturated       (out_tuser)
  );

endmodule
